### hdl/tapqm_pkg.sv
// Shared types, register indexes and a saturation helper for the quad mixer attitude controller.
package tapqm_pkg;

  // Fraction bits of every Q-format value in the datapath.
  localparam int FRAC_W = 16;

  typedef logic signed [31:0] q16_t;   // signed Q16.16
  typedef logic signed [47:0] q32_t;   // signed Q32.16
  typedef logic [23:0]        gain_t;  // unsigned Q8.16
  typedef logic [30:0]        lim_t;   // unsigned Q15.16 limit

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_YAW_PROP_GAIN  = 3'd3,
    REG_YAW_INTEG_GAIN = 3'd4,
    REG_YAW_DERIV_GAIN = 3'd5,
    REG_OUTPUT_LIMIT   = 3'd6,
    REG_WINDUP_LIMIT   = 3'd7
  } cfg_reg_t;

  // Load strobes for the pipeline stages inside each axis.
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
    logic ld_s4;
  } stage_ld_t;

  // Saturate a 33-bit signed value to 32 bits signed.
  function automatic q16_t sat32(input logic signed [32:0] v);
    q16_t res;
    if (v[32] != v[31]) begin
      res = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### hdl/three_axis_pid_quad_mixer.sv
// Top level: configuration registers, stage handshake, three PID axes and the X motor mixer.
//
//  Channel | Ports                          | Payload, low bits first
//  --------+--------------------------------+------------------------------------------------
//  input   | in_tvalid in_tready in_tdata   | 6 x 32-bit Q16.16 angles/commands, throttle 12
//          | in_tuser                       | sample_due, clear_state
//  result  | out_tvalid out_tready out_tdata| motor_1 .. motor_4, 11 bits each
//  config  | cfg_we cfg_addr cfg_wdata      | register index 0..7, data up to 31 bits
//
// One item is taken per cycle while output back-pressure does not stall the stages; out_tvalid
// rises once an item has passed the five registered stages: state update, gain multipliers,
// term clamps, axis sum, motor mix; the first of them loads on the transfer edge itself.
// Each stage holds its item while the one after it is full and stalled, so empty stages
// keep filling under output back-pressure.
// Synchronous active-low reset clears the axis state, the stage valid flags and the
// configuration registers to their defaults.
module three_axis_pid_quad_mixer import tapqm_pkg::*; #(
  parameter int MOTOR_MIN = 1000,
  parameter int MOTOR_MAX = 2000
) (
  input  logic         clk,
  input  logic         rst_n,
  // pitch_target, roll_target, yaw_command, pitch_angle, roll_angle, yaw_angle, throttle
  input  logic [207:0] in_tdata,
  // sample_due, clear_state
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // motor_1, motor_2, motor_3, motor_4
  output logic [47:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);

  localparam int MIX_W = 36;
  localparam logic signed [MIX_W-1:0] MIN_Q = MIX_W'(MOTOR_MIN) << FRAC_W;
  localparam logic signed [MIX_W-1:0] MAX_Q = MIX_W'(MOTOR_MAX) << FRAC_W;

  // Configuration registers.
  gain_t prop_gain_r;
  gain_t integ_gain_r;
  gain_t deriv_gain_r;
  gain_t yaw_prop_gain_r;
  gain_t yaw_integ_gain_r;
  gain_t yaw_deriv_gain_r;
  lim_t  output_limit_r;
  lim_t  windup_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= '0;
      integ_gain_r     <= '0;
      deriv_gain_r     <= '0;
      yaw_prop_gain_r  <= 24'h03_0000;
      yaw_integ_gain_r <= '0;
      yaw_deriv_gain_r <= '0;
      output_limit_r   <= 31'h0190_0000;
      windup_limit_r   <= 31'h00C8_0000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PROP_GAIN:      prop_gain_r      <= cfg_wdata[23:0];
        REG_INTEG_GAIN:     integ_gain_r     <= cfg_wdata[23:0];
        REG_DERIV_GAIN:     deriv_gain_r     <= cfg_wdata[23:0];
        REG_YAW_PROP_GAIN:  yaw_prop_gain_r  <= cfg_wdata[23:0];
        REG_YAW_INTEG_GAIN: yaw_integ_gain_r <= cfg_wdata[23:0];
        REG_YAW_DERIV_GAIN: yaw_deriv_gain_r <= cfg_wdata[23:0];
        REG_OUTPUT_LIMIT:   output_limit_r   <= cfg_wdata;
        REG_WINDUP_LIMIT:   windup_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor moves on.
  logic      v1_r, v2_r, v3_r, v4_r, v5_r;
  logic      rdy1, rdy2, rdy3, rdy4, rdy5;
  logic      ld5;
  stage_ld_t ld;

  assign rdy5      = !v5_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign ld.ld_s1 = in_tvalid && rdy1;
  assign ld.ld_s2 = v1_r && rdy2;
  assign ld.ld_s3 = v2_r && rdy3;
  assign ld.ld_s4 = v3_r && rdy4;
  assign ld5      = v4_r && rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Input fields.
  q16_t        pitch_target, roll_target, yaw_command;
  q16_t        pitch_angle, roll_angle, yaw_angle;
  logic [11:0] throttle;
  logic        sample_due, clear_state;
  q16_t        yaw_measure;

  assign pitch_target = in_tdata[31:0];
  assign roll_target  = in_tdata[63:32];
  assign yaw_command  = in_tdata[95:64];
  assign pitch_angle  = in_tdata[127:96];
  assign roll_angle   = in_tdata[159:128];
  assign yaw_angle    = in_tdata[191:160];
  assign throttle     = in_tdata[203:192];
  assign sample_due   = in_tuser[0];
  assign clear_state  = in_tuser[1];

  // Yaw regulates command plus measured yaw toward zero.
  assign yaw_measure = sat32({yaw_command[31], yaw_command} + {yaw_angle[31], yaw_angle});

  // Throttle rides alongside the axis stages.
  logic [11:0] thr1_r, thr2_r, thr3_r, thr4_r;

  always_ff @(posedge clk) begin
    if (ld.ld_s1) thr1_r <= throttle;
    if (ld.ld_s2) thr2_r <= thr1_r;
    if (ld.ld_s3) thr3_r <= thr2_r;
    if (ld.ld_s4) thr4_r <= thr3_r;
  end

  // The three axes.
  q16_t pitch_out, roll_out, yaw_out;

  tapqm_axis u_pitch (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (ld),
    .setpoint    (pitch_target),
    .measure     (pitch_angle),
    .sample_due  (sample_due),
    .clear_state (clear_state),
    .kp          (prop_gain_r),
    .ki          (integ_gain_r),
    .kd          (deriv_gain_r),
    .out_lim     (output_limit_r),
    .wind_lim    (windup_limit_r),
    .axis_out    (pitch_out)
  );

  tapqm_axis u_roll (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (ld),
    .setpoint    (roll_target),
    .measure     (roll_angle),
    .sample_due  (sample_due),
    .clear_state (clear_state),
    .kp          (prop_gain_r),
    .ki          (integ_gain_r),
    .kd          (deriv_gain_r),
    .out_lim     (output_limit_r),
    .wind_lim    (windup_limit_r),
    .axis_out    (roll_out)
  );

  tapqm_axis u_yaw (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (ld),
    .setpoint    ('0),
    .measure     (yaw_measure),
    .sample_due  (sample_due),
    .clear_state (clear_state),
    .kp          (yaw_prop_gain_r),
    .ki          (yaw_integ_gain_r),
    .kd          (yaw_deriv_gain_r),
    .out_lim     (output_limit_r),
    .wind_lim    (windup_limit_r),
    .axis_out    (yaw_out)
  );

  // X mixer: form each motor sum in signed Q20.16, clamp low first, then high.
  function automatic logic [10:0] motor_clamp(input logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] c;
    if (v < MIN_Q) begin
      c = MIN_Q;
    end else if (v > MAX_Q) begin
      c = MAX_Q;
    end else begin
      c = v;
    end
    return c[FRAC_W+10:FRAC_W];
  endfunction

  logic signed [MIX_W-1:0] thr_q, p_x, r_x, y_x;
  logic signed [MIX_W-1:0] m1, m2, m3, m4;
  logic [47:0]             out_tdata_r;

  assign thr_q = {8'd0, thr4_r, 16'd0};
  assign p_x   = {{4{pitch_out[31]}}, pitch_out};
  assign r_x   = {{4{roll_out[31]}}, roll_out};
  assign y_x   = {{4{yaw_out[31]}}, yaw_out};
  assign m1    = thr_q + p_x + r_x + y_x;
  assign m2    = thr_q + p_x - r_x - y_x;
  assign m3    = thr_q - p_x - r_x + y_x;
  assign m4    = thr_q - p_x + r_x - y_x;

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_tdata_r <= {4'd0, motor_clamp(m4), motor_clamp(m3), motor_clamp(m2),
                      motor_clamp(m1)};
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = v5_r;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An item leaving the last axis stage lands in the result register.
  a_mix_fill: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && rdy5 |=> out_tvalid)
    else $error("mixer stage dropped an item");

  // With a sane motor range, every delivered motor_1 value lies inside it.
  a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (MOTOR_MIN <= MOTOR_MAX) && (MOTOR_MAX < 2048) |->
      (int'(out_tdata[10:0]) >= MOTOR_MIN) && (int'(out_tdata[10:0]) <= MOTOR_MAX))
    else $error("motor_1 outside its range");

endmodule

### hdl/tapqm_axis.sv
// One PID axis: state update on transfer, gain multiplies, term clamps and summing.
module tapqm_axis import tapqm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  stage_ld_t ld,
  input  q16_t      setpoint,
  input  q16_t      measure,
  input  logic      sample_due,
  input  logic      clear_state,
  input  gain_t     kp,
  input  gain_t     ki,
  input  gain_t     kd,
  input  lim_t      out_lim,
  input  lim_t      wind_lim,
  output q16_t      axis_out
);

  // Axis state; these registers also serve as the first stage's payload.
  q32_t int_r;
  q16_t perr_r;
  q16_t pmeas_r;
  q16_t der_r;
  q16_t e1_r;

  q32_t int_base;
  q16_t perr_base;
  q16_t pmeas_base;
  q32_t int_nxt;
  q16_t perr_nxt;
  q16_t pmeas_nxt;
  q16_t der_nxt;
  q16_t err;

  logic signed [32:0] err_diff;
  logic signed [32:0] err_pair;
  logic signed [32:0] err_half;
  logic signed [48:0] int_add;
  logic signed [32:0] der_diff;

  // Error, trapezoidal integral and derivative on measurement.
  assign err_diff = {setpoint[31], setpoint} - {measure[31], measure};
  assign err      = sat32(err_diff);

  always_comb begin
    int_base   = clear_state ? '0 : int_r;
    perr_base  = clear_state ? '0 : perr_r;
    pmeas_base = clear_state ? '0 : pmeas_r;
    err_pair   = {err[31], err} + {perr_base[31], perr_base};
    err_half   = err_pair >>> 1;
    int_add    = {int_base[47], int_base} + {{16{err_half[32]}}, err_half};
    der_diff   = {pmeas_base[31], pmeas_base} - {measure[31], measure};
    if (sample_due) begin
      if (int_add[48] != int_add[47]) begin
        int_nxt = int_add[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        int_nxt = int_add[47:0];
      end
      perr_nxt  = err;
      der_nxt   = sat32(der_diff);
      pmeas_nxt = measure;
    end else begin
      int_nxt   = int_base;
      perr_nxt  = perr_base;
      der_nxt   = der_r;
      pmeas_nxt = pmeas_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r   <= '0;
      perr_r  <= '0;
      pmeas_r <= '0;
      der_r   <= '0;
    end else if (ld.ld_s1) begin
      int_r   <= int_nxt;
      perr_r  <= perr_nxt;
      pmeas_r <= pmeas_nxt;
      der_r   <= der_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_s1) begin
      e1_r <= err;
    end
  end

  // Magnitudes feed unsigned multipliers; the integral is split into a high and a low part.
  logic [31:0] mag_e;
  logic [47:0] mag_i;
  logic [31:0] mag_d;

  assign mag_e = e1_r[31]  ? (~e1_r + 32'd1)  : e1_r;
  assign mag_i = int_r[47] ? (~int_r + 48'd1) : int_r;
  assign mag_d = der_r[31] ? (~der_r + 32'd1) : der_r;

  logic [55:0] pp_r;
  logic [55:0] pih_r;
  logic [39:0] pil_r;
  logic [55:0] pd_r;
  logic        sp2_r;
  logic        si2_r;
  logic        sd2_r;

  always_ff @(posedge clk) begin
    if (ld.ld_s2) begin
      pp_r  <= 56'(kp) * 56'(mag_e);
      pih_r <= 56'(ki) * 56'(mag_i[47:16]);
      pil_r <= 40'(ki) * 40'(mag_i[15:0]);
      pd_r  <= 56'(kd) * 56'(mag_d);
      sp2_r <= e1_r[31];
      si2_r <= int_r[47];
      sd2_r <= der_r[31];
    end
  end

  // Scale back to Q16.16, clamp each magnitude and restore its sign.
  function automatic q16_t signed_term(input logic [55:0] q, input logic neg,
                                       input lim_t lim);
    logic [55:0] c;
    logic [31:0] m;
    c = (q > {25'd0, lim}) ? {25'd0, lim} : q;
    m = c[31:0];
    return neg ? q16_t'(~m + 32'd1) : q16_t'(m);
  endfunction

  logic [55:0] q_p;
  logic [55:0] q_i;
  logic [55:0] q_d;
  q16_t        tp3_r;
  q16_t        ti3_r;
  q16_t        td3_r;

  assign q_p = {16'd0, pp_r[55:16]};
  assign q_i = pih_r + {32'd0, pil_r[39:16]};
  assign q_d = {16'd0, pd_r[55:16]};

  always_ff @(posedge clk) begin
    if (ld.ld_s3) begin
      tp3_r <= signed_term(q_p, sp2_r, out_lim);
      ti3_r <= signed_term(q_i, si2_r, wind_lim);
      td3_r <= signed_term(q_d, sd2_r, out_lim);
    end
  end

  // Sum the three terms, clamp to the output limit and negate.
  logic signed [33:0] sum;
  logic signed [33:0] lim_pos;
  logic signed [33:0] lim_neg;
  logic signed [33:0] sum_clamp;
  logic signed [33:0] sum_neg;
  q16_t               out4_r;

  always_comb begin
    sum     = {{2{tp3_r[31]}}, tp3_r} + {{2{ti3_r[31]}}, ti3_r} + {{2{td3_r[31]}}, td3_r};
    lim_pos = {3'd0, out_lim};
    lim_neg = -lim_pos;
    if (sum > lim_pos) begin
      sum_clamp = lim_pos;
    end else if (sum < lim_neg) begin
      sum_clamp = lim_neg;
    end else begin
      sum_clamp = sum;
    end
    sum_neg = -sum_clamp;
  end

  always_ff @(posedge clk) begin
    if (ld.ld_s4) begin
      out4_r <= sum_neg[31:0];
    end
  end

  assign axis_out = out4_r;

endmodule
